### rtl/mpe_pkg.sv
// ----------------------------------------------------------------------------
// mpe_pkg
// Shared types and constants of the multilinear polynomial evaluator.
// ----------------------------------------------------------------------------
package mpe_pkg;

   localparam int DATA_W      = 32;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int STORE_DEPTH = 8;
   localparam int STORE_AW    = 3;

   localparam int DIM_DEFAULT  = 3;
   localparam int FRAC_DEFAULT = 16;

   // Clamp limits of a signed data word, held at product width
   localparam logic signed [PROD_W-1:0] WORD_MAX = PROD_W'(64'sd2147483647);
   localparam logic signed [PROD_W-1:0] WORD_MIN = -PROD_W'(64'sd2147483648);

   // Item function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EVAL = 1'b1;

   typedef struct packed {
      logic                     func;
      logic [STORE_AW-1:0]      coef_index;
      logic signed [DATA_W-1:0] coef_value;
      logic signed [DATA_W-1:0] coord_0;
      logic signed [DATA_W-1:0] coord_1;
      logic signed [DATA_W-1:0] coord_2;
   } mpe_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] interpolated;
      logic                     overflow;
   } mpe_rsp_type;

   // Control that travels with one term down the datapath
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic ovf;
   } mpe_stage_type;

endpackage

### rtl/mpe_req_if.sv
// ----------------------------------------------------------------------------
// mpe_req_if
// Request channel: valid/ready handshake with an evaluator request word.
// ----------------------------------------------------------------------------
interface mpe_req_if import mpe_pkg::*; ();

   logic        valid;
   logic        ready;
   mpe_req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface

### rtl/mpe_rsp_if.sv
// ----------------------------------------------------------------------------
// mpe_rsp_if
// Response channel: valid/ready handshake with an evaluator result word.
// ----------------------------------------------------------------------------
interface mpe_rsp_if import mpe_pkg::*; ();

   logic        valid;
   logic        ready;
   mpe_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface

### rtl/mpe_ram.sv
// ----------------------------------------------------------------------------
// mpe_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mpe_term_unit.sv
// ----------------------------------------------------------------------------
// mpe_term_unit
// Builds the coordinate product of one term per cycle from the saved
// product of its parent term (the same index with the top axis bit cleared).
// ----------------------------------------------------------------------------
module mpe_term_unit import mpe_pkg::*; #(
   parameter int DIM       = DIM_DEFAULT,
   parameter int FRAC_BITS = FRAC_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mpe_stage_type            ctrl_in,
   input  logic [DIM-1:0]           term_idx,
   input  logic signed [DATA_W-1:0] coords [DIM],
   output mpe_stage_type            ctrl_out,
   output logic signed [DATA_W-1:0] prod_out
);

   localparam int NTERMS = 1 << DIM;
   localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

   logic signed [DATA_W-1:0] partial_ff [NTERMS];
   logic signed [DATA_W-1:0] prod_ff;
   mpe_stage_type            ctrl_ff;

   logic [DIM-1:0]           top_mask;
   logic [DIM-1:0]           parent_idx;
   logic signed [DATA_W-1:0] axis_coord;
   logic signed [DATA_W-1:0] parent_prod;
   logic signed [PROD_W-1:0] raw_prod;
   logic signed [PROD_W-1:0] shifted;
   logic signed [DATA_W-1:0] prod_in;
   logic                     sat_in;

   always_comb begin
      top_mask   = '0;
      axis_coord = '0;
      // keep the highest set axis bit of the term
      for (int j = 0; j < DIM; j++) begin
         if (term_idx[j]) begin
            top_mask    = '0;
            top_mask[j] = 1'b1;
            axis_coord  = coords[j];
         end
      end
      parent_idx  = term_idx & ~top_mask;
      parent_prod = partial_ff[parent_idx];
      raw_prod    = PROD_W'(parent_prod) * PROD_W'(axis_coord);
      shifted     = raw_prod >>> FRAC_BITS;
      sat_in      = 1'b0;
      if (term_idx == '0) begin
         prod_in = ONE;
      end else if (shifted > WORD_MAX) begin
         prod_in = WORD_MAX[DATA_W-1:0];
         sat_in  = 1'b1;
      end else if (shifted < WORD_MIN) begin
         prod_in = WORD_MIN[DATA_W-1:0];
         sat_in  = 1'b1;
      end else begin
         prod_in = shifted[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else begin
         ctrl_ff <= '{valid: ctrl_in.valid,
                      first: ctrl_in.first,
                      last:  ctrl_in.last,
                      ovf:   ctrl_in.valid & sat_in};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_in.valid) begin
         partial_ff[term_idx] <= prod_in;
         prod_ff              <= prod_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign prod_out = prod_ff;

endmodule

### rtl/mpe_mac.sv
// ----------------------------------------------------------------------------
// mpe_mac
// Multiplies each term product by its coefficient, accumulates the terms
// wide and saturates the final sum into the result register.
// ----------------------------------------------------------------------------
module mpe_mac import mpe_pkg::*; #(
   parameter int FRAC_BITS = FRAC_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mpe_stage_type            ctrl_in,
   input  logic signed [DATA_W-1:0] prod_in,
   input  logic signed [DATA_W-1:0] coef_in,
   output logic                     done,
   mpe_rsp_if.source                rsp_chan
);

   mpe_stage_type            ctrl_b_ff;
   logic signed [PROD_W-1:0] mul_ff;
   logic signed [PROD_W-1:0] acc_ff;
   logic                     ovf_acc_ff;
   logic                     rsp_valid_ff;
   mpe_rsp_type              rsp_data_ff;

   logic signed [PROD_W-1:0] mul_raw;
   logic signed [PROD_W-1:0] mul_in;
   logic signed [PROD_W-1:0] acc_in;
   logic                     ovf_acc_in;
   logic signed [DATA_W-1:0] sum_sat;
   logic                     sum_ovf;

   always_comb begin
      mul_raw    = PROD_W'(prod_in) * PROD_W'(coef_in);
      mul_in     = mul_raw >>> FRAC_BITS;
      acc_in     = ctrl_b_ff.first ? mul_ff : acc_ff + mul_ff;
      ovf_acc_in = (ctrl_b_ff.first ? 1'b0 : ovf_acc_ff) | ctrl_b_ff.ovf;
      sum_ovf    = 1'b0;
      if (acc_in > WORD_MAX) begin
         sum_sat = WORD_MAX[DATA_W-1:0];
         sum_ovf = 1'b1;
      end else if (acc_in < WORD_MIN) begin
         sum_sat = WORD_MIN[DATA_W-1:0];
         sum_ovf = 1'b1;
      end else begin
         sum_sat = acc_in[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_b_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctrl_b_ff <= ctrl_in;
         if (ctrl_b_ff.valid && ctrl_b_ff.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_in.valid) begin
         mul_ff <= mul_in;
      end
      if (ctrl_b_ff.valid) begin
         acc_ff     <= acc_in;
         ovf_acc_ff <= ovf_acc_in;
         if (ctrl_b_ff.last) begin
            rsp_data_ff.interpolated <= sum_sat;
            rsp_data_ff.overflow     <= ovf_acc_in | sum_ovf;
         end
      end
   end

   assign done           = ctrl_b_ff.valid & ctrl_b_ff.last;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

### rtl/multilinear_polynomial_evaluator_unit.sv
// ----------------------------------------------------------------------------
// multilinear_polynomial_evaluator_unit: a load writes one coefficient; an
// evaluate sweeps the 2^DIM terms, one term per cycle through the shared MAC,
// raises its result once drained, and takes no new word before it is idle.
// A previous result still waiting on rsp ready holds the sweep until it leaves.
// Reset clears the per-entry valid bits, so every coefficient reads as zero.
// ----------------------------------------------------------------------------
module multilinear_polynomial_evaluator_unit import mpe_pkg::*; #(
   parameter int DIM       = DIM_DEFAULT,
   parameter int FRAC_BITS = FRAC_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   mpe_req_if.sink   req_chan,
   mpe_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type                state_ff;
   logic [DIM-1:0]           idx_ff;
   logic signed [DATA_W-1:0] coord_ff [DIM];
   logic [STORE_DEPTH-1:0]   coef_vld_ff;
   logic                     rd_vld_ff;

   logic signed [DATA_W-1:0] req_coords [3];
   logic                     req_accept;
   logic                     load_we;
   logic                     eval_start;
   logic                     out_free;
   logic [STORE_AW-1:0]      rd_addr;
   logic [DATA_W-1:0]        ram_rd_data;
   logic signed [DATA_W-1:0] coef_word;
   mpe_stage_type            ctrl_a;
   mpe_stage_type            ctrl_b;
   logic signed [DATA_W-1:0] term_prod;
   logic                     mac_done;

   assign req_coords[0] = req_chan.data.coord_0;
   assign req_coords[1] = req_chan.data.coord_1;
   assign req_coords[2] = req_chan.data.coord_2;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid & req_chan.ready;
   assign load_we        = req_accept & (req_chan.data.func == FUNC_LOAD);
   assign eval_start     = req_accept & (req_chan.data.func == FUNC_EVAL);
   // output word is empty or leaves at this edge
   assign out_free       = ~rsp_chan.valid | rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
               if (eval_start) begin
                  state_ff <= out_free ? ST_RUN : ST_WAIT;
                  for (int j = 0; j < DIM; j++) begin
                     coord_ff[j] <= req_coords[j];
                  end
               end
            end
            ST_WAIT: begin
               if (out_free) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               idx_ff <= idx_ff + 1'b1;
               if (&idx_ff) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (mac_done) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rd_addr = STORE_AW'(idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
      end else if (load_we) begin
         coef_vld_ff[req_chan.data.coef_index] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_RUN) begin
         rd_vld_ff <= coef_vld_ff[rd_addr];
      end
   end

   mpe_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_addr (req_chan.data.coef_index),
      .wr_data (req_chan.data.coef_value),
      .rd_en   (state_ff == ST_RUN),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // never-written entries read as zero
   assign coef_word = rd_vld_ff ? $signed(ram_rd_data) : '0;

   always_comb begin
      ctrl_a.valid = (state_ff == ST_RUN);
      ctrl_a.first = (idx_ff == '0);
      ctrl_a.last  = &idx_ff;
      ctrl_a.ovf   = 1'b0;
   end

   mpe_term_unit #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_term (
      .clock    (clock),
      .reset    (reset),
      .ctrl_in  (ctrl_a),
      .term_idx (idx_ff),
      .coords   (coord_ff),
      .ctrl_out (ctrl_b),
      .prod_out (term_prod)
   );

   mpe_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl_in  (ctrl_b),
      .prod_in  (term_prod),
      .coef_in  (coef_word),
      .done     (mac_done),
      .rsp_chan (rsp_chan)
   );

   a_rsp_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(state_ff == ST_DRAIN))
      else $error("result word raised outside drain");

   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (state_ff == ST_DRAIN))
      else $error("accumulator finished outside drain");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !load_we)
      else $error("coefficient write during evaluation");

   a_run_starts_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_RUN) |-> (idx_ff == '0))
      else $error("term sweep did not start at term zero");

endmodule
